[rtl/fdsa_pkg.sv]
// Shared types and constants for the Forth data stack and ALU.
package fdsa_pkg;

  localparam int unsigned CELL_W  = 32;
  localparam int unsigned DEPTH_W = 9;

  typedef enum logic [3:0] {
    K_PUSH = 4'd0,
    K_ADD  = 4'd1,
    K_SUB  = 4'd2,
    K_MUL  = 4'd3,
    K_DIV  = 4'd4,
    K_MOD  = 4'd5,
    K_EQ   = 4'd6,
    K_LT   = 4'd7,
    K_GT   = 4'd8,
    K_DUP  = 4'd9,
    K_DROP = 4'd10,
    K_SWAP = 4'd11,
    K_OVER = 4'd12,
    K_DOT  = 4'd13,
    K_EMIT = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OVER    = 3'd1,
    ST_UNDER   = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_DIVOVF  = 3'd4
  } status_t;

  localparam logic [CELL_W-1:0] CELL_MIN   = 32'h8000_0000;
  localparam logic [CELL_W-1:0] CELL_TRUE  = 32'hFFFF_FFFF;
  localparam logic [6:0]        CHAR_MASK  = 7'h7F;
  localparam logic [6:0]        CHAR_SPACE = 7'd32;

  typedef struct packed {
    logic [3:0]               kind;
    logic signed [CELL_W-1:0] literal;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic                     has_print;
    logic                     print_is_char;
    logic signed [CELL_W-1:0] print_value;
    logic [DEPTH_W-1:0]       stack_depth;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic div_start;
    logic fin;
    logic swap2;
  } fdsa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic div_go;
    logic swap_go;
    logic div_done;
  } fdsa_stat_t;

endpackage

[rtl/fdsa_div.sv]
// Iterative restoring divider for 32-bit unsigned magnitudes, one bit per cycle.
module fdsa_div
  import fdsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CELL_W-1:0] dividend,
  input  logic [CELL_W-1:0] divisor,
  output logic              done,
  output logic [CELL_W-1:0] quotient,
  output logic [CELL_W-1:0] remainder
);

  localparam int unsigned STEP_W = $clog2(CELL_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CELL_W-1:0] rem_r;
  logic [CELL_W-1:0] quo_r;
  logic [CELL_W-1:0] dvs_r;
  logic [CELL_W:0]   rem_sh;
  logic [CELL_W:0]   trial;
  logic              fits;

  assign rem_sh = {rem_r, quo_r[CELL_W-1]};
  assign trial  = rem_sh - {1'b0, dvs_r};
  assign fits   = ~trial[CELL_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(CELL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial[CELL_W-1:0] : rem_sh[CELL_W-1:0];
      quo_r <= {quo_r[CELL_W-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/fdsa_dp.sv]
// Datapath: stack memory, cell count, operand registers, ALU and result register.
module fdsa_dp
  import fdsa_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  fdsa_cmd_t  cmd,
  output fdsa_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [CELL_W-1:0] stack_mem [STACK_DEPTH];

  kind_t             kind_r;
  logic [CELL_W-1:0] lit_r;
  logic [CELL_W-1:0] a_r;
  logic [CELL_W-1:0] b_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [AW-1:0]     addr_top;
  logic [AW-1:0]     addr_sec;
  logic              cnt_zero;
  logic              cnt_lt2;
  logic              cnt_full;
  logic              div_err_zero;
  logic              div_err_ovf;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic              out_load;
  status_t           st;
  logic              hp;
  logic              ic;
  logic [CELL_W-1:0] pv;
  logic [CELL_W-1:0] product;
  logic [CELL_W-1:0] abs_a;
  logic [CELL_W-1:0] abs_b;
  logic [CELL_W-1:0] quo;
  logic [CELL_W-1:0] rem;
  logic [CELL_W-1:0] div_res;
  logic              div_done;
  logic [6:0]        ch;

  assign addr_top = AW'(cnt_r - 1'b1);
  assign addr_sec = AW'(cnt_r - 2'd2);
  assign cnt_zero = (cnt_r == '0);
  assign cnt_lt2  = (cnt_r < CW'(2));
  assign cnt_full = (cnt_r == CW'(STACK_DEPTH));

  assign div_err_zero = (b_r == '0);
  assign div_err_ovf  = (a_r == CELL_MIN) && (b_r == CELL_TRUE);

  assign stat.slot_free = ~out_valid_r | out_ready;
  assign stat.div_go    = ((kind_r == K_DIV) || (kind_r == K_MOD)) && !cnt_lt2 &&
                          !div_err_zero && !div_err_ovf;
  assign stat.swap_go   = (kind_r == K_SWAP) && !cnt_lt2;
  assign stat.div_done  = div_done;

  assign product = a_r * b_r;
  assign abs_a   = a_r[CELL_W-1] ? (~a_r + 1'b1) : a_r;
  assign abs_b   = b_r[CELL_W-1] ? (~b_r + 1'b1) : b_r;

  fdsa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (abs_a),
    .divisor   (abs_b),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // Truncating division: the quotient is negative when the signs differ and
  // the remainder takes the sign of the dividend.
  always_comb begin
    if (kind_r == K_DIV) begin
      div_res = (a_r[CELL_W-1] ^ b_r[CELL_W-1]) ? (~quo + 1'b1) : quo;
    end else begin
      div_res = a_r[CELL_W-1] ? (~rem + 1'b1) : rem;
    end
  end

  assign ch = b_r[6:0] & CHAR_MASK;

  always_comb begin
    cnt_nxt  = cnt_r;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    out_load = 1'b0;
    st       = ST_OK;
    hp       = 1'b0;
    ic       = 1'b0;
    pv       = '0;
    if (cmd.exec) begin
      out_load = ~stat.div_go;
      unique case (kind_r)
        K_PUSH: begin
          if (cnt_full) begin
            st      = ST_OVER;
            cnt_nxt = '0;
          end else begin
            we      = 1'b1;
            waddr   = AW'(cnt_r);
            wdata   = lit_r;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        K_ADD, K_SUB, K_MUL, K_EQ, K_LT, K_GT: begin
          if (cnt_lt2) begin
            st      = ST_UNDER;
            cnt_nxt = '0;
          end else begin
            we      = 1'b1;
            waddr   = addr_sec;
            cnt_nxt = cnt_r - 1'b1;
            unique case (kind_r)
              K_ADD:   wdata = a_r + b_r;
              K_SUB:   wdata = a_r - b_r;
              K_MUL:   wdata = product;
              K_EQ:    wdata = {CELL_W{a_r == b_r}};
              K_LT:    wdata = {CELL_W{$signed(a_r) < $signed(b_r)}};
              default: wdata = {CELL_W{$signed(a_r) > $signed(b_r)}};
            endcase
          end
        end
        K_DIV, K_MOD: begin
          if (cnt_lt2) begin
            st      = ST_UNDER;
            cnt_nxt = '0;
          end else if (div_err_zero) begin
            st      = ST_DIVZERO;
            cnt_nxt = cnt_r - 2'd2;
          end else if (div_err_ovf) begin
            st      = ST_DIVOVF;
            cnt_nxt = cnt_r - 2'd2;
          end
        end
        K_DUP: begin
          if (cnt_zero) begin
            st      = ST_UNDER;
            cnt_nxt = '0;
          end else if (cnt_full) begin
            st      = ST_OVER;
            cnt_nxt = '0;
          end else begin
            we      = 1'b1;
            waddr   = AW'(cnt_r);
            wdata   = b_r;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        K_DROP: begin
          if (cnt_zero) begin
            st      = ST_UNDER;
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        K_SWAP: begin
          if (cnt_lt2) begin
            st      = ST_UNDER;
            cnt_nxt = '0;
          end else begin
            // The old top goes down now; the old second goes up in the next cycle.
            we    = 1'b1;
            waddr = addr_sec;
            wdata = b_r;
          end
        end
        K_OVER: begin
          if (cnt_lt2) begin
            st      = ST_UNDER;
            cnt_nxt = '0;
          end else if (cnt_full) begin
            st      = ST_OVER;
            cnt_nxt = '0;
          end else begin
            we      = 1'b1;
            waddr   = AW'(cnt_r);
            wdata   = a_r;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        K_DOT, K_EMIT: begin
          if (cnt_zero) begin
            st      = ST_UNDER;
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
            hp      = 1'b1;
            if (kind_r == K_EMIT) begin
              ic = 1'b1;
              pv = CELL_W'((ch == 7'd0) ? CHAR_SPACE : ch);
            end else begin
              pv = b_r;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.fin) begin
      out_load = 1'b1;
      we       = 1'b1;
      waddr    = addr_sec;
      wdata    = div_res;
      cnt_nxt  = cnt_r - 1'b1;
    end else if (cmd.swap2) begin
      we    = 1'b1;
      waddr = addr_top;
      wdata = a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[waddr] <= wdata;
    end
    if (cmd.accept) begin
      b_r <= stack_mem[addr_top];
      a_r <= stack_mem[addr_sec];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= kind_t'(in_data.kind);
      lit_r  <= in_data.literal;
    end
    if (out_load) begin
      out_r.status        <= st;
      out_r.has_print     <= hp;
      out_r.print_is_char <= ic;
      out_r.print_value   <= pv;
      out_r.stack_depth   <= DEPTH_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/fdsa_ctrl.sv]
// Controller state machine that sequences each operation through the datapath.
module fdsa_ctrl
  import fdsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  fdsa_stat_t stat,
  output fdsa_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_DIV   = 5'b00100,
    S_FIN   = 5'b01000,
    S_SWAP2 = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.accept    = 1'b0;
    cmd.exec      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.fin       = 1'b0;
    cmd.swap2     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        // Wait here until the result register can take this transaction.
        if (stat.slot_free) begin
          cmd.exec = 1'b1;
          if (stat.div_go) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else if (stat.swap_go) begin
            state_nxt = S_SWAP2;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.slot_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SWAP2: begin
        cmd.swap2 = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/forth_data_stack_alu.sv]
// Top level of the Forth data stack and integer ALU.
//
// Each input transaction on in_valid/in_ready carries one operation (in_data.kind)
// and a literal used only by push. Each operation yields exactly one result
// transaction on out_valid/out_ready: a status code, an optional printed value
// from dot or emit, and the number of cells left on the stack.
//
// An operation is accepted, its two top cells are read from the stack memory
// into registers, and once the result register is free the ALU result is
// written back and the result register is loaded. Swap needs a second write
// because the single memory write port cannot write both cells at once, and div
// and mod wait for the divider, which produces one quotient bit per cycle.
// The result register is loaded with the write-back (the first write for swap).
//
// The result register decouples the two sides: a new operation is accepted
// while an earlier result still waits, and only its completion waits for the
// result register to drain when the receiver stalls.
// After reset the stack is empty; the stack memory is not cleared, since no
// cell value is used before it has been written.
module forth_data_stack_alu
  import fdsa_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  fdsa_cmd_t  cmd;
  fdsa_stat_t stat;

  fdsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fdsa_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sim/forth_data_stack_alu_tb.sv]
// Self-checking testbench for the Forth data stack and ALU, with its own stack predictor.
`timescale 1ns / 100ps

module forth_data_stack_alu_tb;
  import fdsa_pkg::*;

  localparam int unsigned STACK_CELLS = 256;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam logic [3:0]  K_UNUSED    = 4'd15;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Predicted stack contents and the reports still owed by the block.
  logic [CELL_W-1:0] cell_store [STACK_CELLS];
  int unsigned       cell_count;
  out_item_t         op_reports [$];

  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  forth_data_stack_alu #(
    .STACK_DEPTH(STACK_CELLS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void push_cell(logic [CELL_W-1:0] v, inout logic [2:0] st);
    if (cell_count >= STACK_CELLS) begin
      st = ST_OVER;
      cell_count = 0;
    end else begin
      cell_store[cell_count] = v;
      cell_count++;
    end
  endfunction

  function automatic bit pop_cell(output logic [CELL_W-1:0] v, inout logic [2:0] st);
    v = '0;
    if (cell_count == 0) begin
      st = ST_UNDER;
      return 1'b0;
    end
    cell_count--;
    v = cell_store[cell_count];
    return 1'b1;
  endfunction

  // The top cell is b and the one beneath it is a.
  function automatic bit pop_pair(output logic [CELL_W-1:0] a, output logic [CELL_W-1:0] b,
                                  inout logic [2:0] st);
    a = '0;
    if (!pop_cell(b, st)) begin
      return 1'b0;
    end
    return pop_cell(a, st);
  endfunction

  function automatic out_item_t execute_op(in_item_t op);
    out_item_t                rep;
    logic [CELL_W-1:0]        a;
    logic [CELL_W-1:0]        b;
    logic [CELL_W-1:0]        v;
    logic signed [CELL_W-1:0] sa;
    logic signed [CELL_W-1:0] sb;
    logic [2:0]               st;
    rep = '0;
    st = ST_OK;
    case (op.kind)
      K_PUSH: push_cell(op.literal, st);
      K_ADD: if (pop_pair(a, b, st)) push_cell(a + b, st);
      K_SUB: if (pop_pair(a, b, st)) push_cell(a - b, st);
      K_MUL: if (pop_pair(a, b, st)) push_cell(a * b, st);
      K_DIV, K_MOD: begin
        if (pop_pair(a, b, st)) begin
          sa = a;
          sb = b;
          // Both operands are consumed even when nothing is pushed.
          if (b == '0) begin
            st = ST_DIVZERO;
          end else if (a == CELL_MIN && b == CELL_TRUE) begin
            st = ST_DIVOVF;
          end else if (op.kind == K_DIV) begin
            push_cell(sa / sb, st);
          end else begin
            push_cell(sa % sb, st);
          end
        end
      end
      K_EQ: if (pop_pair(a, b, st)) push_cell((a == b) ? CELL_TRUE : '0, st);
      K_LT: if (pop_pair(a, b, st)) push_cell(($signed(a) < $signed(b)) ? CELL_TRUE : '0, st);
      K_GT: if (pop_pair(a, b, st)) push_cell(($signed(a) > $signed(b)) ? CELL_TRUE : '0, st);
      K_DUP: begin
        if (cell_count == 0) begin
          st = ST_UNDER;
        end else begin
          push_cell(cell_store[cell_count - 1], st);
        end
      end
      K_DROP: void'(pop_cell(v, st));
      K_SWAP: begin
        if (pop_pair(a, b, st)) begin
          push_cell(b, st);
          push_cell(a, st);
        end
      end
      K_OVER: begin
        if (cell_count < 2) begin
          st = ST_UNDER;
          cell_count = 0;
        end else begin
          push_cell(cell_store[cell_count - 2], st);
        end
      end
      K_DOT: begin
        if (pop_cell(v, st)) begin
          rep.has_print = 1'b1;
          rep.print_value = v;
        end
      end
      K_EMIT: begin
        if (pop_cell(v, st)) begin
          rep.has_print = 1'b1;
          rep.print_is_char = 1'b1;
          rep.print_value = {25'd0, v[6:0] & CHAR_MASK};
          if (rep.print_value == 0) begin
            rep.print_value = {25'd0, CHAR_SPACE};
          end
        end
      end
      default: begin
      end
    endcase
    rep.status = st;
    rep.stack_depth = DEPTH_W'(cell_count);
    return rep;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(logic [3:0] kind, logic [CELL_W-1:0] lit);
    in_item_t op;
    op.kind = kind;
    op.literal = lit;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    op_reports.push_back(execute_op(op));
    @(negedge clk);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    go_quiet();
    while (op_reports.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic test_each_op();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_op(K_PUSH, 32'h7FFF_FFFF);
    send_op(K_PUSH, CELL_MIN);
    send_op(K_OVER, '0);
    send_op(K_ADD, '0);
    send_op(K_SWAP, '0);
    send_op(K_SUB, '0);
    send_op(K_DUP, '0);
    send_op(K_MUL, '0);
    // The product wraps to zero, which emit shows as a space.
    send_op(K_EMIT, '0);
    send_op(K_PUSH, CELL_TRUE);
    send_op(K_EMIT, '0);
    send_op(K_PUSH, CELL_MIN);
    send_op(K_PUSH, CELL_TRUE);
    send_op(K_DIV, '0);
    send_op(K_PUSH, -32'sd7);
    send_op(K_PUSH, '0);
    send_op(K_MOD, '0);
    send_op(K_PUSH, -32'sd7);
    send_op(K_PUSH, 32'sd2);
    send_op(K_MOD, '0);
    send_op(K_PUSH, 32'sd2);
    send_op(K_DIV, '0);
    send_op(K_PUSH, '0);
    send_op(K_EQ, '0);
    send_op(K_PUSH, 32'sd5);
    send_op(K_GT, '0);
    send_op(K_PUSH, 32'sd3);
    send_op(K_LT, '0);
    send_op(K_DOT, '0);
    send_op(K_UNUSED, $urandom);
  endtask

  task automatic test_stack_limits();
    logic [3:0] fillers [3];
    src_idle_pct = 34;
    sink_stall_pct = 34;
    fillers = '{K_PUSH, K_DUP, K_OVER};
    while (cell_count != 0) begin
      send_op(K_DROP, '0);
    end
    send_op(K_DROP, '0);
    send_op(K_DUP, '0);
    send_op(K_OVER, '0);
    send_op(K_DOT, '0);
    send_op(K_EMIT, '0);
    send_op(K_PUSH, 32'sd1);
    send_op(K_OVER, '0);
    send_op(K_PUSH, 32'sd9);
    send_op(K_ADD, '0);
    // Each growing operation is tried against a full stack.
    foreach (fillers[i]) begin
      while (cell_count < STACK_CELLS) begin
        send_op(K_PUSH, $urandom);
      end
      send_op(fillers[i], $urandom);
    end
  endtask

  function automatic logic [CELL_W-1:0] pick_literal();
    case ($urandom_range(3))
      0: return CELL_W'(int'($urandom_range(16)) - 8);
      1: begin
        case ($urandom_range(4))
          0: return '0;
          1: return CELL_TRUE;
          2: return CELL_MIN;
          3: return 32'h7FFF_FFFF;
          default: return 32'd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed programs that keep the stack shallow, with some noise.
  task automatic test_random_ops(int unsigned count, int unsigned src_pct,
                                 int unsigned sink_pct, bit pause_midway);
    logic [3:0] kind;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (int unsigned n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) begin
        wait_drained();
      end
      if ($urandom_range(99) < 10) begin
        kind = 4'($urandom_range(15));
      end else if (cell_count < 2) begin
        kind = ($urandom_range(4) == 0) ? 4'($urandom_range(K_DUP, K_OVER)) : K_PUSH;
      end else if (cell_count > 40) begin
        kind = ($urandom_range(1) == 0) ? 4'($urandom_range(K_ADD, K_GT)) : K_DOT;
      end else if ($urandom_range(99) < 35) begin
        kind = K_PUSH;
      end else begin
        kind = 4'($urandom_range(K_ADD, K_EMIT));
      end
      send_op(kind, pick_literal());
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic void check_field(string field, logic [CELL_W-1:0] want,
                                      logic [CELL_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_result
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (op_reports.size() == 0) begin
        $display("%0t ns: result transaction with none expected, actual %0h", $time, out_data);
        fail_count++;
      end else begin
        want = op_reports.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("has_print", want.has_print, out_data.has_print);
        check_field("print_is_char", want.print_is_char, out_data.print_is_char);
        check_field("print_value", want.print_value, out_data.print_value);
        check_field("stack_depth", want.stack_depth, out_data.stack_depth);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("** forth_data_stack_alu: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cell_count = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_each_op();
    test_stack_limits();
    test_random_ops(110, 0, 0, 1'b0);
    test_random_ops(110, 68, 0, 1'b1);
    test_random_ops(110, 0, 68, 1'b0);
    test_random_ops(110, 34, 34, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** forth_data_stack_alu: PASSED **");
    end else begin
      $display("** forth_data_stack_alu: FAILED **");
    end
    $finish;
  end

endmodule
